// ===== src/tvlfo_pkg.sv =====
// shared constants and helpers for the tremolo/vibrato lfo core
// no dependencies; imported by tremolo_vibrato_lfo_core
`default_nettype none

package tvlfo_pkg;

  // sine angle resolution, quarter wave takes two bits less
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned QUARTER_BITS    = SINE_TABLE_BITS - 2;

  // shared serial unit widths
  localparam int unsigned OP_W   = 36;
  localparam int unsigned PROD_W = 2 * OP_W;
  localparam int unsigned DVS_W  = 14;
  localparam int unsigned CNT_W  = $clog2(OP_W);

  localparam logic [8:0]        RATE_BASE   = 9'h103;
  localparam logic [6:0]        TREM_BASE   = 7'h7F;
  localparam logic [OP_W-1:0]   GROWTH_Q23  = 36'd8648596;
  localparam logic [OP_W-1:0]   UNITY_Q23   = 36'd8388608;
  localparam logic [OP_W-1:0]   HALF_PI_Q30 = 36'd1686629713;
  localparam logic [OP_W-1:0]   LN2_Q30     = 36'd744261118;
  localparam logic [31:0]       ONE_Q30     = 32'h4000_0000;
  localparam logic [DVS_W-1:0]  VIB_DIV     = 14'd9600;
  localparam logic [OP_W-1:0]   VIB_BIAS    = 36'd4800;
  localparam logic [20:0]       OCT_OFFSET  = 21'd262144;
  localparam logic [15:0]       CENTS_RESET = 16'd16;
  localparam logic [15:0]       UNITY_RATIO = 16'd4096;

  // oscillator kinds
  localparam logic [1:0] KIND_TREM = 2'd0;
  localparam logic [1:0] KIND_VIB  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  // register indexes
  localparam logic [1:0] REG_KIND  = 2'd0;
  localparam logic [1:0] REG_RATE  = 2'd1;
  localparam logic [1:0] REG_DEPTH = 2'd2;

  // divisors of the sine polynomial, innermost term first
  function automatic logic [DVS_W-1:0] sine_div(input logic [1:0] idx);
    logic [DVS_W-1:0] d;
    case (idx)
      2'd0: d = 14'd72;
      2'd1: d = 14'd42;
      2'd2: d = 14'd20;
      default: d = 14'd6;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/tremolo_vibrato_lfo_core.sv =====
// tremolo/vibrato low-frequency sine oscillator, one result per frame transaction
// depends on tvlfo_pkg
`default_nettype none

// The core takes one transaction per audio frame. A restart transaction latches
// the kind, rate and depth registers, clears the phase and returns the initial
// value (tremolo: (127 - depth/2) in Q8.8, vibrato: 1.0 in Q4.12, none: the
// held outputs); it then works out the vibrato depth in cents as 1.031^depth by
// repeated squaring. A tremolo or vibrato tick transaction advances the phase
// modulo 259 - rate, divides it into a sine angle, evaluates a degree-9 sine
// polynomial and forms either the tremolo volume or the vibrato ratio
// 2^(sin*cents/1200) through a degree-8 exponential series. All multiplies
// and divides but the tremolo scaling run through one shared bit-serial unit:
// a shift-add multiplier and a restoring divider that retire one bit a cycle,
// so each operation is a load, 36 bit steps and a write-back. A restart takes
// up to 15 such operations, a tremolo tick 11 and a vibrato tick up to 30. The
// core works on one transaction at a time; a finished result sits in the
// output register while the next transaction is accepted. Register writes are
// always accepted and only act at the next restart.
module tremolo_vibrato_lfo_core
  import tvlfo_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        restart_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      volume_o,
  output logic [15:0]      pitch_ratio_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  // sequencer states
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_CMUL_R  = 5'd1;
  localparam logic [4:0] ST_CMUL_M  = 5'd2;
  localparam logic [4:0] ST_CFIN    = 5'd3;
  localparam logic [4:0] ST_PDIV    = 5'd4;
  localparam logic [4:0] ST_SMUL_U  = 5'd5;
  localparam logic [4:0] ST_SMUL_X2 = 5'd6;
  localparam logic [4:0] ST_SDIV_T  = 5'd7;
  localparam logic [4:0] ST_SMUL_T  = 5'd8;
  localparam logic [4:0] ST_SMUL_S  = 5'd9;
  localparam logic [4:0] ST_TOUT    = 5'd10;
  localparam logic [4:0] ST_VMUL    = 5'd11;
  localparam logic [4:0] ST_VDIV    = 5'd12;
  localparam logic [4:0] ST_VMUL_Y  = 5'd13;
  localparam logic [4:0] ST_HMUL    = 5'd14;
  localparam logic [4:0] ST_HDIV    = 5'd15;
  localparam logic [4:0] ST_VOUT    = 5'd16;
  localparam logic [4:0] ST_FIN     = 5'd17;

  localparam logic [QUARTER_BITS:0] QUARTER = (QUARTER_BITS+1)'(1) << QUARTER_BITS;

  // configuration registers
  logic [1:0] osc_kind_q;
  logic [7:0] rate_q;
  logic [7:0] depth_q;

  // latched oscillator state
  logic [4:0]  state_q;
  logic [1:0]  kind_q;
  logic [8:0]  period_q;
  logic [6:0]  half_q;
  logic [8:0]  phase_q;
  logic [15:0] cents_q;
  logic [15:0] vol_q;
  logic [15:0] ratio_q;
  logic        out_valid_q;
  logic [2:0]  it_q;
  logic [1:0]  ki_q;
  logic [3:0]  k_q;

  // working registers
  logic [OP_W-1:0]     r_q;
  logic [OP_W-1:0]     m_q;
  logic [7:0]          dsh_q;
  logic [31:0]         x_q;
  logic [31:0]         x2_q;
  logic [31:0]         t_q;
  logic [OP_W-1:0]     tmp_q;
  logic [1:0]          quad_q;
  logic [QUARTER_BITS:0] u_q;
  logic [15:0]         smag_q;
  logic                sneg_q;
  logic [2:0]          n_q;
  logic                esat_q;
  logic [15:0]         new_vol_q;
  logic [15:0]         new_ratio_q;

  // serial unit
  logic              busy_q;
  logic              done_q;
  logic              mode_div_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] acc_q;
  logic [OP_W-1:0]   opa_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;

  logic              ld_mul;
  logic              ld_div;
  logic              unit_go;
  logic [OP_W-1:0]   opa;
  logic [OP_W-1:0]   opb;
  logic [DVS_W-1:0]  dvs;

  logic              in_acc;
  logic [8:0]        phase_inc;
  logic [8:0]        phase_next;
  logic [OP_W-1:0]   pdiv_num;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign volume_o      = vol_q;
  assign pitch_ratio_o = ratio_q;
  assign cfg_ready_o   = 1'b1;

  // phase step, wraps at the period
  assign phase_inc  = phase_q + 9'd1;
  assign phase_next = (phase_inc >= period_q) ? 9'd0 : phase_inc;
  assign pdiv_num   = OP_W'({phase_q, {SINE_TABLE_BITS{1'b0}}}) + OP_W'(period_q >> 1);

  // operand selection for the shared unit
  always_comb begin
    ld_mul = 1'b0;
    ld_div = 1'b0;
    opa    = '0;
    opb    = '0;
    dvs    = '0;
    case (state_q)
      ST_CMUL_R: begin
        ld_mul = 1'b1; opa = r_q; opb = m_q;
      end
      ST_CMUL_M: begin
        ld_mul = 1'b1; opa = m_q; opb = m_q;
      end
      ST_PDIV: begin
        ld_div = 1'b1; opb = pdiv_num; dvs = DVS_W'(period_q);
      end
      ST_SMUL_U: begin
        ld_mul = 1'b1; opa = OP_W'(u_q); opb = HALF_PI_Q30;
      end
      ST_SMUL_X2: begin
        ld_mul = 1'b1; opa = OP_W'(x_q); opb = OP_W'(x_q);
      end
      ST_SDIV_T: begin
        ld_div = 1'b1; opb = tmp_q; dvs = sine_div(ki_q);
      end
      ST_SMUL_T: begin
        ld_mul = 1'b1; opa = OP_W'(x2_q); opb = OP_W'(t_q);
      end
      ST_SMUL_S: begin
        ld_mul = 1'b1; opa = OP_W'(x_q); opb = OP_W'(t_q);
      end
      ST_VMUL: begin
        ld_mul = 1'b1; opa = OP_W'(smag_q); opb = OP_W'(cents_q);
      end
      ST_VDIV: begin
        ld_div = 1'b1; opb = tmp_q; dvs = VIB_DIV;
      end
      ST_VMUL_Y: begin
        ld_mul = 1'b1; opa = tmp_q; opb = LN2_Q30;
      end
      ST_HMUL: begin
        ld_mul = 1'b1; opa = OP_W'(x_q); opb = OP_W'(t_q);
      end
      ST_HDIV: begin
        ld_div = 1'b1; opb = tmp_q; dvs = DVS_W'(k_q);
      end
      default: begin
      end
    endcase
  end

  assign unit_go = (ld_mul || ld_div) && !busy_q && !done_q;

  // one bit of multiply or divide per cycle
  logic [OP_W:0]     mul_sum;
  logic [PROD_W-1:0] mul_d;
  logic [DVS_W:0]    div_sh;
  logic [DVS_W:0]    div_diff;
  logic              div_ge;
  logic [DVS_W-1:0]  rem_d;
  logic [PROD_W-1:0] div_d;

  assign mul_sum  = {1'b0, acc_q[PROD_W-1:OP_W]} + (acc_q[0] ? {1'b0, opa_q} : '0);
  assign mul_d    = {mul_sum, acc_q[OP_W-1:1]};
  assign div_sh   = {rem_q, acc_q[OP_W-1]};
  assign div_ge   = (div_sh >= {1'b0, dvs_q});
  assign div_diff = div_sh - {1'b0, dvs_q};
  assign rem_d    = div_ge ? div_diff[DVS_W-1:0] : div_sh[DVS_W-1:0];
  assign div_d    = {acc_q[PROD_W-1:OP_W], acc_q[OP_W-2:0], div_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (unit_go) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(OP_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else if (done_q) begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (unit_go) begin
      mode_div_q <= ld_div;
      acc_q      <= {{OP_W{1'b0}}, opb};
      opa_q      <= opa;
      rem_q      <= '0;
      dvs_q      <= dvs;
    end else if (busy_q) begin
      if (mode_div_q) begin
        acc_q <= div_d;
        rem_q <= rem_d;
      end else begin
        acc_q <= mul_d;
      end
    end
  end

  // write-back arithmetic on the unit result
  logic [PROD_W-1:0]      p_r23;
  logic [PROD_W-1:0]      p_x;
  logic [PROD_W-1:0]      p_y;
  logic [OP_W:0]          cents_sum;
  logic [17:0]            cents_full;
  logic [15:0]            cents_sat;
  logic [1:0]             a_quad;
  logic [QUARTER_BITS:0]  a_u;
  logic [32:0]            s_sum;
  logic [17:0]            s_rnd;
  logic [15:0]            s_sat;
  logic [19:0]            vq;
  logic [20:0]            e_val;
  logic                   e_sat;

  assign p_r23      = acc_q + (PROD_W'(1) << 22);
  assign p_x        = acc_q + (PROD_W'(1) << (QUARTER_BITS - 1));
  assign p_y        = acc_q + PROD_W'(32768);
  assign cents_sum  = {1'b0, r_q} + (OP_W+1)'(262144);
  assign cents_full = cents_sum[36:19];
  assign cents_sat  = (cents_full > 18'h0FFFF) ? 16'hFFFF : cents_full[15:0];

  // quadrant fold of the sine angle
  assign a_quad = acc_q[SINE_TABLE_BITS-1:QUARTER_BITS];
  assign a_u    = a_quad[0] ? (QUARTER - {1'b0, acc_q[QUARTER_BITS-1:0]})
                            : {1'b0, acc_q[QUARTER_BITS-1:0]};

  // sine in q30 rounded to q15, clamped at one
  assign s_sum = {1'b0, acc_q[61:30]} + 33'd16384;
  assign s_rnd = s_sum[32:15];
  assign s_sat = (s_rnd > 18'd32768) ? 16'h8000 : s_rnd[15:0];

  // exponent in q16 octaves, offset by four octaves
  assign vq    = acc_q[19:0];
  assign e_val = sneg_q ? ((21'(vq) > OCT_OFFSET) ? 21'd0 : (OCT_OFFSET - 21'(vq)))
                        : (OCT_OFFSET + 21'(vq));
  assign e_sat = e_val[20] || e_val[19];

  // tremolo volume
  logic signed [16:0] sn;
  logic [6:0]         trem_base;
  logic signed [24:0] trem_prod;
  logic signed [25:0] trem_acc;
  logic signed [18:0] trem_v;
  logic [15:0]        trem_vol;

  assign sn        = sneg_q ? -$signed({1'b0, smag_q}) : $signed({1'b0, smag_q});
  assign trem_base = TREM_BASE - half_q;
  assign trem_prod = $signed({1'b0, half_q}) * sn;
  assign trem_acc  = $signed({4'b0, trem_base, 15'b0}) + $signed({trem_prod[24], trem_prod})
                   + 26'sd64;
  assign trem_v    = trem_acc[25:7];
  always_comb begin
    if (trem_v > 19'sd32767) begin
      trem_vol = 16'h7FFF;
    end else if (trem_v < -19'sd32768) begin
      trem_vol = 16'h8000;
    end else begin
      trem_vol = trem_v[15:0];
    end
  end

  // vibrato ratio: q30 power of two shifted down to q4.12
  logic [4:0]  vib_sh;
  logic [32:0] vib_add;
  logic [32:0] vib_res;
  logic [15:0] vib_ratio;

  assign vib_sh    = 5'd22 - {2'b0, n_q};
  assign vib_add   = {1'b0, t_q} + (33'd1 << (vib_sh - 5'd1));
  assign vib_res   = vib_add >> vib_sh;
  assign vib_ratio = (esat_q || (vib_res[32:16] != '0)) ? 16'hFFFF : vib_res[15:0];

  // sequencer and latched state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_kind_q  <= KIND_NONE;
      rate_q      <= '0;
      depth_q     <= '0;
      state_q     <= ST_IDLE;
      kind_q      <= KIND_NONE;
      period_q    <= RATE_BASE;
      half_q      <= '0;
      phase_q     <= '0;
      cents_q     <= CENTS_RESET;
      vol_q       <= '0;
      ratio_q     <= '0;
      out_valid_q <= 1'b0;
      it_q        <= '0;
      ki_q        <= '0;
      k_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_KIND:  osc_kind_q <= cfg_data_i[1:0];
          REG_RATE:  rate_q     <= cfg_data_i;
          REG_DEPTH: depth_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
      // the commit in the final state sets valid itself
      if (out_ready_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (restart_i) begin
              kind_q   <= osc_kind_q;
              period_q <= RATE_BASE - {1'b0, rate_q};
              half_q   <= depth_q[7:1];
              phase_q  <= '0;
              it_q     <= '0;
              state_q  <= depth_q[0] ? ST_CMUL_R : ST_CMUL_M;
            end else if (kind_q == KIND_TREM || kind_q == KIND_VIB) begin
              phase_q <= phase_next;
              state_q <= ST_PDIV;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_CMUL_R: begin
          if (done_q) begin
            state_q <= (it_q == 3'd7) ? ST_CFIN : ST_CMUL_M;
          end
        end
        ST_CMUL_M: begin
          if (done_q) begin
            it_q <= it_q + 3'd1;
            if (dsh_q[1]) begin
              state_q <= ST_CMUL_R;
            end else begin
              state_q <= (it_q == 3'd6) ? ST_CFIN : ST_CMUL_M;
            end
          end
        end
        ST_CFIN: begin
          cents_q <= cents_sat;
          state_q <= ST_FIN;
        end
        ST_PDIV: begin
          if (done_q) state_q <= ST_SMUL_U;
        end
        ST_SMUL_U: begin
          if (done_q) state_q <= ST_SMUL_X2;
        end
        ST_SMUL_X2: begin
          if (done_q) begin
            ki_q    <= '0;
            state_q <= ST_SDIV_T;
          end
        end
        ST_SDIV_T: begin
          if (done_q) begin
            if (ki_q == 2'd3) begin
              state_q <= ST_SMUL_S;
            end else begin
              ki_q    <= ki_q + 2'd1;
              state_q <= ST_SMUL_T;
            end
          end
        end
        ST_SMUL_T: begin
          if (done_q) state_q <= ST_SDIV_T;
        end
        ST_SMUL_S: begin
          if (done_q) state_q <= (kind_q == KIND_VIB) ? ST_VMUL : ST_TOUT;
        end
        ST_TOUT: begin
          state_q <= ST_FIN;
        end
        ST_VMUL: begin
          if (done_q) state_q <= ST_VDIV;
        end
        ST_VDIV: begin
          if (done_q) state_q <= e_sat ? ST_VOUT : ST_VMUL_Y;
        end
        ST_VMUL_Y: begin
          if (done_q) begin
            k_q     <= 4'd8;
            state_q <= ST_HMUL;
          end
        end
        ST_HMUL: begin
          if (done_q) state_q <= ST_HDIV;
        end
        ST_HDIV: begin
          if (done_q) begin
            k_q     <= k_q - 4'd1;
            state_q <= (k_q == 4'd1) ? ST_VOUT : ST_HMUL;
          end
        end
        ST_VOUT: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            vol_q       <= new_vol_q;
            ratio_q     <= new_ratio_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath write-back
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (restart_i) begin
            r_q   <= UNITY_Q23;
            m_q   <= GROWTH_Q23;
            dsh_q <= depth_q;
            if (osc_kind_q == KIND_TREM) begin
              new_vol_q   <= {1'b0, TREM_BASE - depth_q[7:1], 8'b0};
              new_ratio_q <= '0;
            end else if (osc_kind_q == KIND_VIB) begin
              new_vol_q   <= '0;
              new_ratio_q <= UNITY_RATIO;
            end else begin
              new_vol_q   <= vol_q;
              new_ratio_q <= ratio_q;
            end
          end else begin
            new_vol_q   <= vol_q;
            new_ratio_q <= ratio_q;
          end
        end
      end
      ST_CMUL_R: begin
        if (done_q) r_q <= p_r23[OP_W+22:23];
      end
      ST_CMUL_M: begin
        if (done_q) begin
          m_q   <= p_r23[OP_W+22:23];
          dsh_q <= dsh_q >> 1;
        end
      end
      ST_PDIV: begin
        if (done_q) begin
          quad_q <= a_quad;
          u_q    <= a_u;
        end
      end
      ST_SMUL_U: begin
        if (done_q) x_q <= p_x[QUARTER_BITS+31:QUARTER_BITS];
      end
      ST_SMUL_X2: begin
        if (done_q) begin
          x2_q  <= acc_q[61:30];
          tmp_q <= OP_W'(acc_q[61:30]);
        end
      end
      ST_SDIV_T: begin
        if (done_q) t_q <= ONE_Q30 - acc_q[31:0];
      end
      ST_SMUL_T: begin
        if (done_q) tmp_q <= acc_q[OP_W+29:30];
      end
      ST_SMUL_S: begin
        if (done_q) begin
          smag_q <= s_sat;
          sneg_q <= quad_q[1];
        end
      end
      ST_TOUT: begin
        new_vol_q   <= trem_vol;
        new_ratio_q <= '0;
      end
      ST_VMUL: begin
        if (done_q) tmp_q <= acc_q[OP_W-1:0] + VIB_BIAS;
      end
      ST_VDIV: begin
        if (done_q) begin
          tmp_q  <= OP_W'(e_val[15:0]);
          n_q    <= e_val[18:16];
          esat_q <= e_sat;
        end
      end
      ST_VMUL_Y: begin
        if (done_q) begin
          x_q <= p_y[47:16];
          t_q <= ONE_Q30;
        end
      end
      ST_HMUL: begin
        if (done_q) tmp_q <= acc_q[OP_W+29:30];
      end
      ST_HDIV: begin
        if (done_q) t_q <= ONE_Q30 + acc_q[31:0];
      end
      ST_VOUT: begin
        new_vol_q   <= '0;
        new_ratio_q <= vib_ratio;
      end
      default: begin
      end
    endcase
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(busy_q && done_q))
    else $error("serial unit busy and done together");

  assert property (@(posedge clk_i) disable iff (!rst_ni) phase_q < period_q)
    else $error("phase outside the period");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cents_q >= CENTS_RESET)
    else $error("depth in cents below one cent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_FIN) |-> (!busy_q && !done_q))
    else $error("result committed with the serial unit still running");

endmodule

`default_nettype wire
